// ----- rtl/hblf_pkg.sv -----
// Shared types and constants for the HTTP body length framer.
// Holds the phase encoding, header event struct and keyword table.
// No dependencies.
`default_nettype none

package hblf_pkg;

  // Framing phase, also reported on the result channel
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2,
    PH_ERROR  = 2'd3
  } phase_t;

  // Header parser events for the current item
  typedef struct packed {
    logic hdr_end;   // single-byte line closed by newline
    logic len_zero;  // declared length is zero after this item
  } hdr_evt_t;

  localparam logic [4:0] KEY_LEN  = 5'd14;
  localparam logic [4:0] SKIP_END = 5'd16;

  localparam logic [7:0] ASCII_NL = 8'h0a;
  localparam logic [7:0] ASCII_0  = 8'h30;
  localparam logic [7:0] ASCII_9  = 8'h39;

  // "Content-Length", one character per index
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h4c; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hblf_header.sv -----
// Header parser: keyword match, skip, decimal length capture, line tracking.
// Depends on hblf_pkg.
`default_nettype none

module hblf_header #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic [7:0]             data_byte,
  output logic [LENGTH_BITS-1:0]      declared_len,
  output hblf_pkg::hdr_evt_t          evt
);

  localparam int PW = LENGTH_BITS + 4;

  logic [1:0]             line_pos_r, line_pos_nxt;
  logic [4:0]             key_pos_r, key_pos_nxt;
  logic                   dig_act_r, dig_act_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;

  logic          is_digit;
  logic [PW-1:0] len_ext;
  logic [PW-1:0] prod;

  assign is_digit = data_byte inside {[hblf_pkg::ASCII_0:hblf_pkg::ASCII_9]};

  // len*10 + digit as shift-add, with headroom for the overflow test
  assign len_ext = {4'b0000, len_r};
  assign prod    = (len_ext << 3) + (len_ext << 1) + {{(PW-4){1'b0}}, data_byte[3:0]};

  // Keyword, skip and digit capture
  always_comb begin
    key_pos_nxt = key_pos_r;
    dig_act_nxt = dig_act_r;
    len_nxt     = len_r;
    if (dig_act_r) begin
      if (is_digit) begin
        if (prod[PW-1:LENGTH_BITS] != 4'b0000) begin
          len_nxt = {LENGTH_BITS{1'b1}};
        end else begin
          len_nxt = prod[LENGTH_BITS-1:0];
        end
      end else begin
        dig_act_nxt = 1'b0;
      end
    end else if (key_pos_r >= hblf_pkg::KEY_LEN) begin
      key_pos_nxt = key_pos_r + 5'd1;
      if (key_pos_nxt >= hblf_pkg::SKIP_END) begin
        key_pos_nxt = 5'd0;
        dig_act_nxt = 1'b1;
      end
    end else if (len_r == '0) begin
      if (data_byte == hblf_pkg::key_char(key_pos_r[3:0])) begin
        key_pos_nxt = key_pos_r + 5'd1;
      end else if (data_byte == hblf_pkg::key_char(4'd0)) begin
        key_pos_nxt = 5'd1;
      end else begin
        key_pos_nxt = 5'd0;
      end
    end
  end

  // Line length tracking, saturating at two
  always_comb begin
    line_pos_nxt = line_pos_r;
    evt.hdr_end  = 1'b0;
    if (data_byte == hblf_pkg::ASCII_NL) begin
      evt.hdr_end  = (line_pos_r == 2'd1);
      line_pos_nxt = 2'd0;
    end else if (line_pos_r < 2'd2) begin
      line_pos_nxt = line_pos_r + 2'd1;
    end
    evt.len_zero = (len_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r <= 2'd0;
      key_pos_r  <= 5'd0;
      dig_act_r  <= 1'b0;
      len_r      <= '0;
    end else if (step) begin
      line_pos_r <= line_pos_nxt;
      key_pos_r  <= key_pos_nxt;
      dig_act_r  <= dig_act_nxt;
      len_r      <= len_nxt;
    end
  end

  assign declared_len = len_r;

endmodule

`default_nettype wire

// ----- rtl/hblf_body.sv -----
// Body byte counter: counts passed body bytes and flags the last one.
// No package dependency.
`default_nettype none

module hblf_body #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic [LENGTH_BITS-1:0] declared_len,
  output logic                        last
);

  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;

  // count wraps at the length width
  assign cnt_nxt = cnt_r + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign last    = (cnt_nxt >= declared_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/http_body_length_framer.sv -----
// Top level of the HTTP body length framer: input register, phase control,
// header parser and body counter, result register. Depends on hblf_pkg,
// hblf_header and hblf_body.
//
// Usage: feed the HTTP response one byte per item on the in_ channel
// (in_valid/in_ready/in_data_byte). Every input item yields exactly one
// result item on the out_ channel: out_body_valid marks a body byte,
// out_body_byte carries it (zero otherwise), out_body_last flags the final
// byte of the declared Content-Length, and out_phase_status reports the
// phase after the item (0 header, 1 body, 2 done, 3 error: no length).
// Each accepted item passes the input register and then the result register;
// throughput is one item per clock while out_ready does not stall, set by
// the combinational parser and counter update between the two registers.
// When out_ready is low the result register holds and the input register
// still takes one more item; in_ready then drops until the result drains.
// Synchronous active-low reset returns to the header phase with all
// counters cleared and both pipeline registers empty.
`default_nettype none

module http_body_length_framer #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_body_valid,
  output logic [7:0]      out_body_byte,
  output logic            out_body_last,
  output logic [1:0]      out_phase_status
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       proc;

  hblf_pkg::phase_t   phase_r, phase_nxt;
  hblf_pkg::hdr_evt_t hdr_evt;
  logic [LENGTH_BITS-1:0] declared_len;
  logic                   body_last;

  logic       res_vld_r;
  logic       res_bvld_r, res_bvld_nxt;
  logic [7:0] res_byte_r, res_byte_nxt;
  logic       res_last_r, res_last_nxt;

  // Advance when an item is staged and the result slot is free or draining
  assign proc     = in_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !in_vld_r || proc;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_data_byte;
    end
  end

  hblf_header #(.LENGTH_BITS(LENGTH_BITS)) u_header (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (proc && (phase_r == hblf_pkg::PH_HEADER)),
    .data_byte    (in_byte_r),
    .declared_len (declared_len),
    .evt          (hdr_evt)
  );

  hblf_body #(.LENGTH_BITS(LENGTH_BITS)) u_body (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (proc && (phase_r == hblf_pkg::PH_BODY)),
    .declared_len (declared_len),
    .last         (body_last)
  );

  // Phase next state
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      hblf_pkg::PH_HEADER: begin
        if (hdr_evt.hdr_end) begin
          phase_nxt = hdr_evt.len_zero ? hblf_pkg::PH_ERROR : hblf_pkg::PH_BODY;
        end
      end
      hblf_pkg::PH_BODY: begin
        if (body_last) begin
          phase_nxt = hblf_pkg::PH_DONE;
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // Result fields for the staged item
  always_comb begin
    res_bvld_nxt = 1'b0;
    res_byte_nxt = 8'h00;
    res_last_nxt = 1'b0;
    case (phase_r)
      hblf_pkg::PH_BODY: begin
        res_bvld_nxt = 1'b1;
        res_byte_nxt = in_byte_r;
        res_last_nxt = body_last;
      end
      default: begin
        res_bvld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hblf_pkg::PH_HEADER;
    end else if (proc) begin
      phase_r <= phase_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (proc) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_bvld_r <= res_bvld_nxt;
      res_byte_r <= res_byte_nxt;
      res_last_r <= res_last_nxt;
    end
  end

  // phase register already holds the status of the item in the result slot
  assign out_valid        = res_vld_r;
  assign out_body_valid   = res_bvld_r;
  assign out_body_byte    = res_byte_r;
  assign out_body_last    = res_last_r;
  assign out_phase_status = phase_r;

endmodule

`default_nettype wire

// ----- rtl/hblf_checker.sv -----
// Port-level checks for the HTTP body length framer, bound to the top level.
// Depends on hblf_pkg and http_body_length_framer.
`default_nettype none

module hblf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_body_valid,
  input wire logic [7:0] out_body_byte,
  input wire logic       out_body_last,
  input wire logic [1:0] out_phase_status
);

  // last byte is a body byte and closes the body
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_body_last |->
      out_body_valid && (out_phase_status == hblf_pkg::PH_DONE))
    else $error("last flag without body byte in done phase");

  // body bytes only in body or done phase, non-body items carry zero
  a_body_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_body_valid ? ((out_phase_status == hblf_pkg::PH_BODY) ||
                         (out_phase_status == hblf_pkg::PH_DONE))
                      : (out_body_byte == 8'h00)))
    else $error("body byte in wrong phase or nonzero idle byte");

  // done and error are terminal
  a_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready &&
      ((out_phase_status == hblf_pkg::PH_DONE) ||
       (out_phase_status == hblf_pkg::PH_ERROR)) |=>
      !out_valid || (out_phase_status == $past(out_phase_status)))
    else $error("left a terminal phase");

  // no body byte after the done phase was reported
  a_no_body_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_phase_status == hblf_pkg::PH_DONE) |=>
      !(out_valid && out_body_valid))
    else $error("body byte after done");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_body_byte) && $stable(out_phase_status))
    else $error("stalled result changed");

endmodule

bind http_body_length_framer hblf_checker u_hblf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_body_valid   (out_body_valid),
  .out_body_byte    (out_body_byte),
  .out_body_last    (out_body_last),
  .out_phase_status (out_phase_status)
);

`default_nettype wire

// ----- tb/hblf_frame_checker.sv -----
// Result checker for the HTTP body length framer testbench.
// Watches both channels, predicts each result from the accepted bytes and
// compares field by field. Depends on hblf_pkg.
`default_nettype none

module hblf_frame_checker #(
  parameter int LEN_W = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic       out_body_valid,
  input  wire logic [7:0] out_body_byte,
  input  wire logic       out_body_last,
  input  wire logic [1:0] out_phase_status,
  output int              fail_count,
  output int              pending,
  output int              n_in,
  output int              n_body
);

  // One predicted result item
  typedef struct packed {
    logic             body_valid;
    logic [7:0]       body_byte;
    logic             body_last;
    hblf_pkg::phase_t status;
  } frame_t;

  localparam logic [8*14-1:0] KEYWORD = "Content-Length";
  localparam logic [63:0]     LEN_MAX = (64'd1 << LEN_W) - 64'd1;

  // Predicted framer state
  hblf_pkg::phase_t frame_phase;
  logic [1:0]       line_pos;
  logic [4:0]       key_pos;
  logic             digits_on;
  logic [LEN_W-1:0] decl_len;
  logic [LEN_W-1:0] passed;

  frame_t expected_frames[$];

  // Advance the predicted state by one byte and return the result item
  function automatic frame_t frame_byte(input logic [7:0] b);
    frame_t     r;
    logic [63:0] acc;
    r = '0;
    if (frame_phase == hblf_pkg::PH_HEADER) begin
      if (digits_on) begin
        if (b >= hblf_pkg::ASCII_0 && b <= hblf_pkg::ASCII_9) begin
          acc = 64'(decl_len);
          acc = acc * 64'd10 + 64'(b) - 64'(hblf_pkg::ASCII_0);
          decl_len = (acc > LEN_MAX) ? LEN_MAX[LEN_W-1:0] : acc[LEN_W-1:0];
        end else begin
          // first non-digit ends capture and is not reused for matching
          digits_on = 1'b0;
        end
      end else if (key_pos >= hblf_pkg::KEY_LEN) begin
        // skipping the separator after the keyword
        key_pos = key_pos + 5'd1;
        if (key_pos >= hblf_pkg::SKIP_END) begin
          key_pos   = 5'd0;
          digits_on = 1'b1;
        end
      end else if (decl_len == '0) begin
        if (b == KEYWORD[8*(13 - key_pos) +: 8])
          key_pos = key_pos + 5'd1;
        else
          key_pos = (b == KEYWORD[8*13 +: 8]) ? 5'd1 : 5'd0;
      end
      // line tracking: a one-byte line closed by newline ends the header
      if (b == hblf_pkg::ASCII_NL) begin
        if (line_pos == 2'd1)
          frame_phase = (decl_len == '0) ? hblf_pkg::PH_ERROR : hblf_pkg::PH_BODY;
        line_pos = 2'd0;
      end else if (line_pos < 2'd2) begin
        line_pos = line_pos + 2'd1;
      end
    end else if (frame_phase == hblf_pkg::PH_BODY) begin
      r.body_valid = 1'b1;
      r.body_byte  = b;
      passed = passed + {{(LEN_W-1){1'b0}}, 1'b1};
      if (passed >= decl_len) begin
        r.body_last = 1'b1;
        frame_phase = hblf_pkg::PH_DONE;
      end
    end
    r.status = frame_phase;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      frame_phase = hblf_pkg::PH_HEADER;
      line_pos    = '0;
      key_pos     = '0;
      digits_on   = 1'b0;
      decl_len    = '0;
      passed      = '0;
      fail_count  = 0;
      n_in        = 0;
      n_body      = 0;
      expected_frames.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_frames.push_back(frame_byte(in_data_byte));
        n_in++;
      end
      if (out_valid && out_ready) begin
        if (out_body_valid)
          n_body++;
        if (expected_frames.size() == 0) begin
          $display("%0t unexpected result item: expected none, actual %0h/%0h/%0h/%0h",
                   $time, out_body_valid, out_body_byte, out_body_last, out_phase_status);
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          check_field("body_valid", want.body_valid, out_body_valid);
          check_field("body_byte", want.body_byte, out_body_byte);
          check_field("body_last", want.body_last, out_body_last);
          check_field("phase_status", want.status, out_phase_status);
        end
      end
    end
    pending = expected_frames.size();
  end

endmodule

`default_nettype wire

// ----- tb/http_body_length_framer_test.sv -----
// Testbench top for the HTTP body length framer: clock, reset, byte
// stimulus, receiver stalls, watchdog and verdict. Depends on hblf_pkg,
// http_body_length_framer and hblf_frame_checker.
`default_nettype none

module http_body_length_framer_test;

  localparam int         ITEMS       = 1350;
  localparam int         STALL_LIMIT = 2000;
  localparam int         HOLD_CYCLES = 60;
  localparam int         DRAIN       = 8;
  localparam logic [7:0] ASCII_CR    = 8'h0d;

  typedef enum {RUN_BODY, RUN_MISSING, RUN_SATURATED} run_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_body_valid;
  logic [7:0] out_body_byte;
  logic       out_body_last;
  logic [1:0] out_phase_status;

  int    fail_count;
  int    pending;
  int    n_in;
  int    n_body;
  int    sent;
  bit    quiet;
  bit    held;
  int    hold_left;
  run_t  run_mode;
  string kw_text = "Content-Length";

  http_body_length_framer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_body_valid   (out_body_valid),
    .out_body_byte    (out_body_byte),
    .out_body_last    (out_body_last),
    .out_phase_status (out_phase_status)
  );

  hblf_frame_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_body_valid   (out_body_valid),
    .out_body_byte    (out_body_byte),
    .out_body_last    (out_body_last),
    .out_phase_status (out_phase_status),
    .fail_count       (fail_count),
    .pending          (pending),
    .n_in             (n_in),
    .n_body           (n_body)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, one long hold-off, a quiet stretch
  initial begin
    out_ready = 1'b0;
    held      = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && sent >= 200) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // Watchdog: ends the run when no item moves for too long
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic logic [7:0] any_but_nl();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == hblf_pkg::ASCII_NL);
    return b;
  endfunction

  // Offer one byte with a random gap before it; returns after acceptance
  task automatic put_byte(input logic [7:0] b);
    int gap;
    gap   = 0;
    quiet = (sent >= 600 && sent < 800);
    while (!quiet && $urandom_range(0, 99) < 34)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++)
      put_byte(s.getc(i));
  endtask

  task automatic put_crlf();
    put_byte(ASCII_CR);
    put_byte(hblf_pkg::ASCII_NL);
  endtask

  // Header line of noise: empty, or two or more bytes, often with keyword pieces
  task automatic noise_line();
    int         n;
    logic [7:0] b;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(2, 24);
    if (n > 0 && $urandom_range(0, 4) == 0)
      put_text(kw_text.substr(0, $urandom_range(0, 12)));
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        b = kw_text.getc($urandom_range(0, 13));
      else
        b = any_but_nl();
      put_byte(b);
    end
    put_byte(hblf_pkg::ASCII_NL);
  endtask

  // Keyword line; the two skipped bytes are usually ": "
  task automatic length_line(input string digits);
    put_text(kw_text);
    if ($urandom_range(0, 3) == 0) begin
      put_byte(any_but_nl());
      put_byte(any_but_nl());
    end else begin
      put_text(": ");
    end
    put_text(digits);
    put_crlf();
  endtask

  // Keyword lines that leave the length at zero
  task automatic decoy_line();
    case ($urandom_range(0, 4))
      0: length_line("0");
      1: length_line("000");
      2: length_line("-5");
      3: length_line("");
      default: length_line(" 7");
    endcase
  endtask

  // One byte then newline: ends the header
  task automatic header_end();
    put_byte(($urandom_range(0, 1) == 1) ? ASCII_CR : any_but_nl());
    put_byte(hblf_pkg::ASCII_NL);
  endtask

  // Stimulus and verdict
  initial begin
    int    body_len;
    int    head_target;
    string digits;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    sent         = 0;
    quiet        = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty line, keyword restart, near-complete keyword, byte extremes
    put_byte(hblf_pkg::ASCII_NL);
    put_text("CoContent-LengtX");
    put_crlf();
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(hblf_pkg::ASCII_NL);

    case ($urandom_range(0, 3))
      0:       run_mode = RUN_MISSING;
      1:       run_mode = RUN_SATURATED;
      default: run_mode = RUN_BODY;
    endcase
    body_len = 0;
    digits   = "";
    case (run_mode)
      RUN_BODY: begin
        body_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(900, 1100);
        digits   = $sformatf("%0d", body_len);
        if ($urandom_range(0, 3) == 0)
          digits = {"00", digits};
      end
      RUN_SATURATED: begin
        body_len = 1000;
        case ($urandom_range(0, 2))
          0:       digits = "4294967295";
          1:       digits = "4294967296";
          default: digits = "99999999999999999999";
        endcase
      end
      default: body_len = 0;
    endcase
    head_target = ITEMS - body_len - 40;
    if (head_target < 200)
      head_target = 200;

    // Header before the real length: noise and zero-length keyword lines
    while (sent < head_target) begin
      if ($urandom_range(0, 3) == 0)
        decoy_line();
      else
        noise_line();
    end

    if (run_mode != RUN_MISSING) begin
      length_line(digits);
      noise_line();
      // a second keyword line must not change the length
      length_line("55");
    end
    header_end();

    repeat (body_len)
      put_byte(8'($urandom_range(0, 255)));

    // trailing bytes: no body output once framing ended, body bytes if the length saturated
    repeat (12)
      put_byte(8'($urandom_range(0, 255)));

    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("covered %s stream: %0d bytes in, %0d body bytes out, one long receiver hold-off",
             run_mode.name(), n_in, n_body);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
